// ===== design/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

   // Operation codes carried on req_func; the fourth code is a no-op.
   typedef enum logic [1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_REMOVE = 2'd2
   } func_type;

   // Per-operation control broadcast to every cell of the chain.
   typedef struct packed {
      logic cmp_en;    // capture compare flag against the incoming priority
      logic enq_go;    // commit an enqueue this cycle
      logic ins_mode;  // enqueue places by priority rather than at the tail
      logic deq_go;    // commit a dequeue this cycle
   } ctrl_type;

endpackage

`default_nettype wire

// ===== design/spq_cell.sv =====
`default_nettype none

module spq_cell
   import spq_pkg::*;
#(
   parameter int INDEX         = 0,
   parameter int CW            = 5,
   parameter int PAYLOAD_BITS  = 32,
   parameter int PRIORITY_BITS = 16
) (
   input  wire logic                            clock,
   input  wire ctrl_type                        ctrl,
   input  wire logic [CW-1:0]                   count,
   input  wire logic signed [PRIORITY_BITS-1:0] cmp_prio,
   input  wire logic signed [PRIORITY_BITS-1:0] new_prio,
   input  wire logic [PAYLOAD_BITS-1:0]         new_payload,
   input  wire logic signed [PRIORITY_BITS-1:0] left_prio,
   input  wire logic [PAYLOAD_BITS-1:0]         left_payload,
   input  wire logic signed [PRIORITY_BITS-1:0] right_prio,
   input  wire logic [PAYLOAD_BITS-1:0]         right_payload,
   input  wire logic                            after_in,
   output logic                                 after_out,
   output logic signed [PRIORITY_BITS-1:0]      prio_out,
   output logic [PAYLOAD_BITS-1:0]              payload_out
);

   logic signed [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic [PAYLOAD_BITS-1:0]         payload_ff, payload_in;
   logic                            ge_ff, ge_in;
   logic                            at_tail, occupied, hit, mark;

   always_comb begin
      at_tail  = (CW'(INDEX) == count);
      occupied = (CW'(INDEX) < count);
      // head cell hits only when the new priority is strictly below it;
      // later cells when their priority is not below the new one
      hit      = ge_ff;
      mark     = ctrl.enq_go && (at_tail || (ctrl.ins_mode && occupied && hit));
      after_out = after_in | mark;

      if (ctrl.cmp_en) begin
         ge_in = (INDEX == 0) ? (prio_ff > cmp_prio) : (prio_ff >= cmp_prio);
      end else begin
         ge_in = ge_ff;
      end

      prio_in    = prio_ff;
      payload_in = payload_ff;
      if (ctrl.deq_go) begin
         prio_in    = right_prio;
         payload_in = right_payload;
      end else if (ctrl.enq_go) begin
         if (mark && !after_in) begin
            prio_in    = new_prio;
            payload_in = new_payload;
         end else if (after_in) begin
            prio_in    = left_prio;
            payload_in = left_payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      prio_ff    <= prio_in;
      payload_ff <= payload_in;
      ge_ff      <= ge_in;
   end

   assign prio_out    = prio_ff;
   assign payload_out = payload_ff;

endmodule

`default_nettype wire

// ===== design/sorted_priority_queue.sv =====
// Bounded priority queue built as a row of DEPTH entry cells, head at cell 0.
// An operation is accepted when start is high and busy is low; busy then stays
// high for one cycle, during which no new operation is accepted. In the accept
// cycle every cell compares its stored priority with the incoming one; in the
// next cycle the cells resolve the insert point along the chain and shift
// left or right together. The result appears on the rsp_ ports, with rsp_strobe
// high for one cycle, in the cycle after busy was high; it cannot be held off,
// and a new operation may already be started in that same cycle.
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH         = 16,
   parameter int PAYLOAD_BITS  = 32,
   parameter int PRIORITY_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [1:0]                      req_func,
   input  wire logic signed [PRIORITY_BITS-1:0] req_item_priority,
   input  wire logic [PAYLOAD_BITS-1:0]         req_item_payload,
   output logic                                 rsp_strobe,
   output logic [PAYLOAD_BITS-1:0]              rsp_out_payload,
   output logic signed [PRIORITY_BITS-1:0]      rsp_out_priority,
   output logic                                 rsp_out_valid,
   output logic                                 rsp_was_empty,
   output logic                                 rsp_was_full,
   output logic [$clog2(DEPTH+1)-1:0]           rsp_fill_count
);

   localparam int CW = $clog2(DEPTH + 1);

   logic                            busy_ff, busy_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [1:0]                      func_ff;
   logic signed [PRIORITY_BITS-1:0] op_prio_ff;
   logic [PAYLOAD_BITS-1:0]         op_payload_ff;

   logic                            strobe_ff;
   logic [PAYLOAD_BITS-1:0]         out_payload_ff, out_payload_in;
   logic signed [PRIORITY_BITS-1:0] out_prio_ff, out_prio_in;
   logic                            valid_ff, empty_ff, full_ff;
   logic                            empty_in, full_in;

   logic                            accept, is_enq, is_ins, is_deq, full, empty;
   ctrl_type                        ctrl;

   logic signed [PRIORITY_BITS-1:0] cell_prio    [DEPTH];
   logic [PAYLOAD_BITS-1:0]         cell_payload [DEPTH];
   logic [DEPTH-1:0]                cell_after;

   always_comb begin
      accept = start && !busy_ff;
      is_ins = (func_ff == FUNC_INSERT);
      is_enq = (func_ff == FUNC_APPEND) || is_ins;
      is_deq = (func_ff == FUNC_REMOVE);
      full   = (count_ff == CW'(DEPTH));
      empty  = (count_ff == '0);

      ctrl.cmp_en   = accept;
      ctrl.enq_go   = busy_ff && is_enq && !full;
      ctrl.ins_mode = is_ins;
      ctrl.deq_go   = busy_ff && is_deq && !empty;

      busy_in  = accept;
      count_in = count_ff;
      if (ctrl.enq_go) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.deq_go) begin
         count_in = count_ff - CW'(1);
      end

      out_payload_in = ctrl.deq_go ? cell_payload[0] : '0;
      out_prio_in    = ctrl.deq_go ? cell_prio[0] : '0;
      empty_in       = is_deq && empty;
      full_in        = is_enq && full;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [PRIORITY_BITS-1:0] left_prio, right_prio;
      logic [PAYLOAD_BITS-1:0]         left_payload, right_payload;
      logic                            after_prev;

      always_comb begin
         if (i == 0) begin
            left_prio    = op_prio_ff;
            left_payload = op_payload_ff;
            after_prev   = 1'b0;
         end else begin
            left_prio    = cell_prio[(i == 0) ? 0 : i - 1];
            left_payload = cell_payload[(i == 0) ? 0 : i - 1];
            after_prev   = cell_after[(i == 0) ? 0 : i - 1];
         end
         // last cell shifts in its own contents; that slot is vacated anyway
         right_prio    = cell_prio[(i == DEPTH - 1) ? i : i + 1];
         right_payload = cell_payload[(i == DEPTH - 1) ? i : i + 1];
      end

      spq_cell #(
         .INDEX         (i),
         .CW            (CW),
         .PAYLOAD_BITS  (PAYLOAD_BITS),
         .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .count         (count_ff),
         .cmp_prio      (req_item_priority),
         .new_prio      (op_prio_ff),
         .new_payload   (op_payload_ff),
         .left_prio     (left_prio),
         .left_payload  (left_payload),
         .right_prio    (right_prio),
         .right_payload (right_payload),
         .after_in      (after_prev),
         .after_out     (cell_after[i]),
         .prio_out      (cell_prio[i]),
         .payload_out   (cell_payload[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         count_ff  <= count_in;
         strobe_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff       <= req_func;
         op_prio_ff    <= req_item_priority;
         op_payload_ff <= req_item_payload;
      end
      if (busy_ff) begin
         out_payload_ff <= out_payload_in;
         out_prio_ff    <= out_prio_in;
         valid_ff       <= ctrl.deq_go;
         empty_ff       <= empty_in;
         full_ff        <= full_in;
      end
   end

   assign busy             = busy_ff;
   assign rsp_strobe       = strobe_ff;
   assign rsp_out_payload  = out_payload_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_out_valid    = valid_ff;
   assign rsp_was_empty    = empty_ff;
   assign rsp_was_full     = full_ff;
   assign rsp_fill_count   = count_ff;

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("busy held longer than one cycle");

   a_strobe_follows_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> strobe_ff)
      else $error("commit without result strobe");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.deq_go |=> count_ff == $past(count_ff) - CW'(1))
      else $error("dequeue did not decrement count");

   a_insert_once: assert property (@(posedge clock) disable iff (reset)
      ctrl.enq_go |-> cell_after[DEPTH-1] || (count_ff == CW'(DEPTH - 1)))
      else $error("enqueue found no insert slot");

endmodule

`default_nettype wire
